// File: src/kpd_pkg.sv
package kpd_pkg;

    localparam int unsigned KEY_W     = 4;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD_M1  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_KEY_LIMIT = 4'd3;

    localparam logic [15:0] RST_SETTLE_TICKS   = 16'd2000;
    localparam logic [15:0] RST_PWM_PERIOD_M1  = 16'd999;
    localparam logic [12:0] RST_DUTY_STEP      = 13'd100;
    localparam logic [3:0]  RST_DUTY_KEY_LIMIT = 4'd10;

    typedef struct packed {
        logic [3:0] row_levels;
        logic       scan_request;
    } t_kpd_in;

    typedef struct packed {
        logic [3:0]  column_drive;
        logic [3:0]  key_code;
        logic        key_found;
        logic        scan_done;
        logic [15:0] compare_value;
        logic        pwm_out;
    } t_kpd_out;

    function automatic logic [KEY_W-1:0] key_lookup(input logic [3:0] idx);
        logic [KEY_W-1:0] k;
        case (idx)
            4'd0:    k = 4'h1;
            4'd1:    k = 4'h4;
            4'd2:    k = 4'h7;
            4'd3:    k = 4'hE;
            4'd4:    k = 4'h2;
            4'd5:    k = 4'h5;
            4'd6:    k = 4'h8;
            4'd7:    k = 4'h0;
            4'd8:    k = 4'h3;
            4'd9:    k = 4'h6;
            4'd10:   k = 4'h9;
            4'd11:   k = 4'hF;
            4'd12:   k = 4'hA;
            4'd13:   k = 4'hB;
            4'd14:   k = 4'hC;
            default: k = 4'hD;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] top_row(input logic [3:0] pressed);
        logic [1:0] r;
        if (pressed[3]) begin
            r = 2'd3;
        end else if (pressed[2]) begin
            r = 2'd2;
        end else if (pressed[1]) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

endpackage

// File: src/keypad_scan_pwm_duty.sv
// Matrix keypad scanner that sets a PWM duty value from the decoded key.
// Each input item is one timebase tick carrying the four row levels (active
// low) and a scan request. Every accepted item produces exactly one output
// item with the column drive, the last key code, key-found and scan-done
// strobes, the PWM compare value and the PWM output for that tick.
// The block computes each item in one pass of short logic into an output
// register, and one item can be accepted every cycle while o_in_stall is
// low. A second output stage absorbs one item while the receiver stalls;
// o_in_stall rises only when both output stages hold items.
// The configuration channel is always ready and writes one register per
// handshake; unknown indexes are ignored. Writes are expected while idle.
// Reset returns the scanner to idle with all columns low, clears the key
// code, compare value and PWM counter, loads the default register values
// and empties both output stages.
module keypad_scan_pwm_duty #(
    parameter int unsigned NUM_COLUMNS = 4,
    parameter int unsigned NUM_ROWS    = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  kpd_pkg::t_kpd_in                  i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output kpd_pkg::t_kpd_out                 o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kpd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import kpd_pkg::*;

    localparam logic [3:0] ROW_MASK = 4'((1 << NUM_ROWS) - 1);
    localparam logic [2:0] LAST_COL = 3'(NUM_COLUMNS);

    logic [15:0] r_settle_ticks;
    logic [15:0] r_pwm_period_m1;
    logic [12:0] r_duty_step;
    logic [3:0]  r_duty_key_limit;

    logic        r_scan_active, n_scan_active;
    logic [1:0]  r_column_index, n_column_index;
    logic [15:0] r_settle_count, n_settle_count;
    logic [3:0]  r_key_value, n_key_value;
    logic [15:0] r_compare, n_compare;
    logic [15:0] r_pwm_count, n_pwm_count;

    logic        r_out_valid;
    t_kpd_out    r_out;
    logic        r_skid_valid;
    t_kpd_out    r_skid;

    logic        accept;
    logic        out_fire;
    t_kpd_out    result;
    logic [15:0] count_inc;
    logic [3:0]  pressed;
    logic [3:0]  key_new;
    logic [16:0] product;
    logic        found;
    logic        done;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign count_inc = r_settle_count + 16'd1;
    assign pressed   = ~i_in_item.row_levels & ROW_MASK;
    assign key_new   = key_lookup({r_column_index, top_row(pressed)});
    assign product   = 17'(key_new) * 17'(r_duty_step);

    always_comb begin
        n_scan_active  = r_scan_active;
        n_column_index = r_column_index;
        n_settle_count = r_settle_count;
        n_key_value    = r_key_value;
        n_compare      = r_compare;
        found          = 1'b0;
        done           = 1'b0;
        if (!r_scan_active) begin
            if (i_in_item.scan_request) begin
                n_scan_active  = 1'b1;
                n_column_index = 2'd0;
                n_settle_count = 16'd0;
            end
        end else begin
            n_settle_count = count_inc;
            if (count_inc >= r_settle_ticks) begin
                if (pressed != 4'd0) begin
                    n_key_value = key_new;
                    if (key_new <= r_duty_key_limit) begin
                        n_compare = product[16] ? 16'hFFFF : product[15:0];
                    end
                    found         = 1'b1;
                    done          = 1'b1;
                    n_scan_active = 1'b0;
                end else if ({1'b0, r_column_index} + 3'd1 >= LAST_COL) begin
                    done          = 1'b1;
                    n_scan_active = 1'b0;
                end else begin
                    n_column_index = r_column_index + 2'd1;
                    n_settle_count = 16'd0;
                end
            end
        end
        n_pwm_count = (r_pwm_count >= r_pwm_period_m1) ? 16'd0 : r_pwm_count + 16'd1;

        result.column_drive  = n_scan_active ? ~(4'd1 << n_column_index) : 4'd0;
        result.key_code      = n_key_value;
        result.key_found     = found;
        result.scan_done     = done;
        result.compare_value = n_compare;
        result.pwm_out       = r_pwm_count < n_compare;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks   <= RST_SETTLE_TICKS;
            r_pwm_period_m1  <= RST_PWM_PERIOD_M1;
            r_duty_step      <= RST_DUTY_STEP;
            r_duty_key_limit <= RST_DUTY_KEY_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SETTLE_TICKS:   r_settle_ticks   <= i_cfg_data;
                REG_PWM_PERIOD_M1:  r_pwm_period_m1  <= i_cfg_data;
                REG_DUTY_STEP:      r_duty_step      <= i_cfg_data[12:0];
                REG_DUTY_KEY_LIMIT: r_duty_key_limit <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_active  <= 1'b0;
            r_column_index <= 2'd0;
            r_settle_count <= 16'd0;
            r_key_value    <= 4'd0;
            r_compare      <= 16'd0;
            r_pwm_count    <= 16'd0;
        end else if (accept) begin
            r_scan_active  <= n_scan_active;
            r_column_index <= n_column_index;
            r_settle_count <= n_settle_count;
            r_key_value    <= n_key_value;
            r_compare      <= n_compare;
            r_pwm_count    <= n_pwm_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                end
            end else if (accept) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

endmodule
